### rtl/core/baa_pkg.sv
// Shared constants, the arctangent table and the stage record for the bearing pipeline.
package baa_pkg;

  localparam int CORDIC_STAGES = 20;
  localparam int FRACTION_BITS = 16;
  localparam int GUARD_BITS    = 24;
  localparam int ANGLE_BITS    = 30;
  localparam int TABLE_LEN     = 24;
  localparam int ITERS         = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  // Scaled difference plus room for the CORDIC gain and the diagonal length.
  localparam int WORK_W  = DIFF_W + GUARD_BITS + 3;
  localparam int ANGLE_W = 34;
  localparam int OUT_W   = 19;

  localparam int ROUND_SHIFT = ANGLE_BITS - FRACTION_BITS;
  localparam int ROUND_W     = ANGLE_W - ROUND_SHIFT + 1;

  localparam logic signed [ANGLE_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ANGLE_W-1:0] ROUND_HALF  =
      ANGLE_W'(64'sd1 <<< (ROUND_SHIFT - 1));
  localparam logic signed [ANGLE_W-1:0] PI_OUT      = (PI_Q30 + ROUND_HALF) >>> ROUND_SHIFT;

  typedef struct packed {
    logic signed [WORK_W-1:0]  x;
    logic signed [WORK_W-1:0]  y;
    logic signed [ANGLE_W-1:0] z;
    logic                      special;
  } cordic_t;

  // atan(2^-i) in units of 2^-30 rad.
  function automatic logic signed [ANGLE_W-1:0] atan_q30(input int unsigned idx);
    logic signed [ANGLE_W-1:0] a;
    case (idx)
      0:       a = 34'sd843314857;
      1:       a = 34'sd497837830;
      2:       a = 34'sd263043837;
      3:       a = 34'sd133525159;
      4:       a = 34'sd67021687;
      5:       a = 34'sd33543516;
      6:       a = 34'sd16775851;
      7:       a = 34'sd8388437;
      8:       a = 34'sd4194283;
      9:       a = 34'sd2097149;
      10:      a = 34'sd1048576;
      11:      a = 34'sd524288;
      12:      a = 34'sd262144;
      13:      a = 34'sd131072;
      14:      a = 34'sd65536;
      15:      a = 34'sd32768;
      16:      a = 34'sd16384;
      17:      a = 34'sd8192;
      18:      a = 34'sd4096;
      19:      a = 34'sd2048;
      20:      a = 34'sd1024;
      21:      a = 34'sd512;
      22:      a = 34'sd256;
      23:      a = 34'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### rtl/core/bearing_angle_atan2.sv
// Pipelined CORDIC bearing from a current point to a goal point.
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   input   | in_valid, in_stall, goal_x/y, current_x/y  | in
//   output  | out_valid, out_stall, bearing              | out
//
// One point pair enters per cycle while in_stall is low; the path runs through a difference
// stage, a quadrant stage, one stage per CORDIC iteration and a rounding stage into the output register.
// rst is synchronous and clears every stage valid bit; payload registers are not reset.
// Each stage holds only while it is full and the stage after it holds, so bubbles close up
// and a transfer is still taken while a finished bearing waits on out_stall, as long as a stage is empty.
module bearing_angle_atan2 import baa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] goal_x,
  input  logic signed [COORD_W-1:0] goal_y,
  input  logic signed [COORD_W-1:0] current_x,
  input  logic signed [COORD_W-1:0] current_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [OUT_W-1:0]   bearing
);

  logic                     d_valid;
  logic                     d_ready;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;

  logic [ITERS:0] c_valid;
  logic [ITERS:0] c_ready;
  cordic_t        c [ITERS+1];
  cordic_t        c0_next;

  logic                      out_take;
  logic signed [ROUND_W-1:0] rnd;
  logic signed [ROUND_W-1:0] clamped;

  assign out_take = !out_valid || !out_stall;
  assign c_ready[ITERS] = !c_valid[ITERS] || out_take;
  assign d_ready  = !d_valid || c_ready[0];
  assign in_stall = !d_ready;

  // Difference stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (d_ready) begin
      d_valid <= in_valid;
    end
    if (in_valid && d_ready) begin
      dx <= DIFF_W'(goal_x) - DIFF_W'(current_x);
      dy <= DIFF_W'(goal_y) - DIFF_W'(current_y);
    end
  end

  // Quadrant stage: axis cases are settled here, the left half plane is turned by pi/2.
  always_comb begin
    logic signed [WORK_W-1:0] xs;
    logic signed [WORK_W-1:0] ys;
    xs = WORK_W'(dx) <<< GUARD_BITS;
    ys = WORK_W'(dy) <<< GUARD_BITS;
    c0_next.special = (dx == '0) || (dy == '0);
    c0_next.x = xs;
    c0_next.y = ys;
    c0_next.z = '0;
    if (dx == '0) begin
      c0_next.z = (dy > 0) ? HALF_PI_Q30 : -HALF_PI_Q30;
    end else if (dy == '0) begin
      c0_next.z = (dx > 0) ? '0 : -PI_Q30;
    end else if (dx < 0) begin
      if (dy > 0) begin
        c0_next.x = ys;
        c0_next.y = -xs;
        c0_next.z = HALF_PI_Q30;
      end else begin
        c0_next.x = -ys;
        c0_next.y = xs;
        c0_next.z = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid[0] <= 1'b0;
    end else if (c_ready[0]) begin
      c_valid[0] <= d_valid;
    end
    if (d_valid && c_ready[0]) begin
      c[0] <= c0_next;
    end
  end

  // One CORDIC iteration per stage; items settled at the quadrant stage pass unchanged.
  for (genvar k = 0; k < ITERS; k++) begin : g_iter
    cordic_t nxt;

    assign c_ready[k] = !c_valid[k] || c_ready[k+1];

    always_comb begin
      logic signed [WORK_W-1:0] xs;
      logic signed [WORK_W-1:0] ys;
      xs = $signed(c[k].x) >>> k;
      ys = $signed(c[k].y) >>> k;
      nxt = c[k];
      if (!c[k].special) begin
        if ($signed(c[k].y) > 0) begin
          nxt.x = c[k].x + ys;
          nxt.y = c[k].y - xs;
          nxt.z = c[k].z + atan_q30(k);
        end else begin
          nxt.x = c[k].x - ys;
          nxt.y = c[k].y + xs;
          nxt.z = c[k].z - atan_q30(k);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        c_valid[k+1] <= 1'b0;
      end else if (c_ready[k+1]) begin
        c_valid[k+1] <= c_valid[k];
      end
      if (c_valid[k] && c_ready[k+1]) begin
        c[k+1] <= nxt;
      end
    end
  end

  // Round half up to the output fraction and saturate at pi.
  always_comb begin
    logic signed [ANGLE_W-1:0] zs;
    logic signed [ROUND_W-1:0] zr;
    zs = c[ITERS].z + ROUND_HALF;
    zr = ROUND_W'(zs >>> ROUND_SHIFT);
    rnd = zr;
    if (rnd > ROUND_W'(PI_OUT)) begin
      clamped = ROUND_W'(PI_OUT);
    end else if (rnd < -ROUND_W'(PI_OUT)) begin
      clamped = -ROUND_W'(PI_OUT);
    end else begin
      clamped = rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= c_valid[ITERS];
    end
    if (c_valid[ITERS] && out_take) begin
      bearing <= clamped[OUT_W-1:0];
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && (c_valid == '0) && !d_valid)
    else $error("pipeline not empty after reset");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
      in_valid && !in_stall |=> d_valid)
    else $error("accepted transfer did not reach the difference stage");

  a_right_half: assert property (@(posedge clk) disable iff (rst)
      c_valid[0] && !c[0].special |-> $signed(c[0].x) > 0)
    else $error("quadrant stage left a vector outside the right half plane");

  a_special_angle: assert property (@(posedge clk) disable iff (rst)
      c_valid[ITERS] && c[ITERS].special |->
      (c[ITERS].z == '0) || (c[ITERS].z == HALF_PI_Q30) ||
      (c[ITERS].z == -HALF_PI_Q30) || (c[ITERS].z == -PI_Q30))
    else $error("axis case angle was changed by the iterations");

  a_range: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> ($signed(bearing) <= $signed(PI_OUT[OUT_W-1:0])) &&
      ($signed(bearing) >= -$signed(PI_OUT[OUT_W-1:0])))
    else $error("bearing beyond pi");

endmodule
